// File: design/tccw_pkg.sv
// package for the text console character writer
// types, codes and defaults shared by the controller, datapath and top level
`default_nettype none

package tccw_pkg;

    // screen geometry defaults
    localparam int COLUMNS_DEF  = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 4;

    // field widths
    localparam int ADDR_W = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
    localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;

    // item kinds
    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // control bytes
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic cnt_zero;
        logic cnt_bottom;
        logic cnt_inc;
        logic copy_rd;
        logic blank_wr;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
        logic scroll;
        logic cnt_last_cell;
        logic cnt_copy_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/tccw_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/tccw_ctrl.sv
// controller state machine: clearing pass, idle, scroll copy and bottom row blanking
// depends on tccw_pkg
`default_nettype none

module tccw_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tccw_pkg::dp_status_t  status,
    output tccw_pkg::ctrl_cmd_t        cmd
);

    tccw_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tccw_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.cnt_last_cell) begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = tccw_pkg::ST_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            tccw_pkg::ST_IDLE: begin
                s_ready    = !status.out_busy;
                cmd.accept = s_valid && !status.out_busy;
                if (cmd.accept && status.scroll) begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = tccw_pkg::ST_COPY;
                end
            end
            tccw_pkg::ST_COPY: begin
                cmd.copy_rd = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (status.cnt_copy_last) begin
                    state_next = tccw_pkg::ST_DRAIN;
                end
            end
            tccw_pkg::ST_DRAIN: begin
                // last copied cell is written back here
                cmd.cnt_bottom = 1'b1;
                state_next     = tccw_pkg::ST_BLANK;
            end
            tccw_pkg::ST_BLANK: begin
                cmd.blank_wr = 1'b1;
                if (status.cnt_last_cell) begin
                    cmd.cnt_zero = 1'b1;
                    state_next   = tccw_pkg::ST_IDLE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            default: begin
                state_next = tccw_pkg::ST_CLEAR;
            end
        endcase
    end

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == tccw_pkg::ST_IDLE)
        else $error("ready raised outside idle");

    a_copy_to_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tccw_pkg::ST_COPY && status.cnt_copy_last)
            |=> state_reg == tccw_pkg::ST_DRAIN)
        else $error("copy sweep did not end in drain");

    a_drain_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tccw_pkg::ST_DRAIN |=> state_reg == tccw_pkg::ST_BLANK)
        else $error("drain lasted more than one cycle");

endmodule

`default_nettype wire

// File: design/tccw_datapath.sv
// datapath: cursor, attribute, sweep counter, screen ram and output register
// depends on tccw_pkg and tccw_ram
`default_nettype none

module tccw_datapath #(
    parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tccw_pkg::ctrl_cmd_t           cmd,
    output tccw_pkg::dp_status_t               status,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tccw_pkg::ATTR_W-1:0]   cfg_wr_data,
    input  wire logic                          s_kind,
    input  wire logic [tccw_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic [tccw_pkg::ADDR_W-1:0]   s_read_address,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [tccw_pkg::ADDR_W-1:0]   m_cursor_position,
    output logic      [tccw_pkg::ADDR_W-1:0]   m_cell_address,
    output logic      [tccw_pkg::CELL_W-1:0]   m_cell_value,
    output logic                               m_cell_written,
    output logic                               m_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int SW    = CW + 5;
    localparam int PW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int PAW   = tccw_pkg::ADDR_W;
    localparam int CLW   = tccw_pkg::CELL_W;

    logic [RW-1:0]                 row_reg, row_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic [PW-1:0]                 phase_reg, phase_next;
    logic [tccw_pkg::ATTR_W-1:0]   attr_reg;
    logic [AW-1:0]                 cnt_reg, cnt_next;
    logic                          copy_pend_reg;
    logic [AW-1:0]                 copy_addr_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [PAW-1:0]                pos_reg;
    logic [PAW-1:0]                addr_reg;
    logic [CLW-1:0]                value_reg;
    logic                          from_ram_reg;
    logic                          written_reg;
    logic                          scrolled_reg;

    logic           is_put, is_nl, is_cr, is_tab, is_print;
    logic [SW-1:0]  col_sum;
    logic           wrap, row_inc, scroll;
    logic [RW-1:0]  row_new;
    logic [CW-1:0]  col_new;
    logic [PW-1:0]  phase_new;
    logic [AW-1:0]  cur_addr, new_pos;
    logic           put_wr, read_hit;
    logic [CLW-1:0] put_cell;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [CLW-1:0]  ram_wdata, ram_rdata;

    // cursor arithmetic for a put
    always_comb begin
        is_put   = (s_kind == tccw_pkg::KIND_PUT);
        is_nl    = (s_char_code == tccw_pkg::CH_NEWLINE);
        is_cr    = (s_char_code == tccw_pkg::CH_RETURN);
        is_tab   = (s_char_code == tccw_pkg::CH_TAB);
        is_print = !(is_nl || is_cr || is_tab);

        priority if (is_nl || is_cr) begin
            col_sum = '0;
        end else if (is_tab) begin
            // phase tracks column modulo the tab stop
            col_sum = SW'(col_reg) + SW'(TAB_STOP) - SW'(phase_reg);
        end else begin
            col_sum = SW'(col_reg) + SW'(1);
        end

        wrap    = (col_sum >= SW'(COLUMNS));
        row_inc = is_nl || wrap;
        scroll  = row_inc && (row_reg == RW'(ROWS - 1));
        row_new = (row_inc && !scroll) ? row_reg + RW'(1) : row_reg;
        col_new = wrap ? '0 : CW'(col_sum);

        if (is_print && !wrap) begin
            phase_new = (phase_reg == PW'(TAB_STOP - 1)) ? '0 : phase_reg + PW'(1);
        end else begin
            phase_new = '0;
        end

        cur_addr = AW'(row_reg * COLUMNS) + AW'(col_reg);
        new_pos  = AW'(row_new * COLUMNS) + AW'(col_new);
        put_cell = {attr_reg, s_char_code};
        put_wr   = cmd.accept && is_put && is_print;
        read_hit = (int'(s_read_address) < CELLS);
    end

    // screen ram ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = tccw_pkg::CELL_RESET;
        priority if (cmd.clr_wr) begin
            ram_we = 1'b1;
        end else if (put_wr) begin
            ram_we    = 1'b1;
            ram_waddr = cur_addr;
            ram_wdata = put_cell;
        end else if (copy_pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = copy_addr_reg;
            ram_wdata = ram_rdata;
        end else if (cmd.blank_wr) begin
            ram_we    = 1'b1;
            ram_wdata = {attr_reg, tccw_pkg::CH_SPACE};
        end
        ram_re    = (cmd.accept && !is_put) || cmd.copy_rd;
        ram_raddr = cmd.copy_rd ? cnt_reg + AW'(COLUMNS) : AW'(s_read_address);
    end

    always_comb begin
        priority if (cmd.cnt_zero) begin
            cnt_next = '0;
        end else if (cmd.cnt_bottom) begin
            cnt_next = AW'(CELLS - COLUMNS);
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + AW'(1);
        end else begin
            cnt_next = cnt_reg;
        end

        if (cmd.accept && is_put) begin
            row_next   = row_new;
            col_next   = col_new;
            phase_next = phase_new;
        end else begin
            row_next   = row_reg;
            col_next   = col_reg;
            phase_next = phase_reg;
        end

        m_valid_next = cmd.accept || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            attr_reg      <= tccw_pkg::ATTR_RESET;
            cnt_reg       <= '0;
            copy_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            copy_pend_reg <= cmd.copy_rd;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        copy_addr_reg <= cnt_reg;
        if (cmd.accept) begin
            pos_reg      <= is_put ? PAW'(new_pos) : PAW'(cur_addr);
            if (is_put) begin
                addr_reg <= is_print ? PAW'(cur_addr) : '0;
            end else begin
                addr_reg <= s_read_address;
            end
            value_reg    <= (is_put && is_print) ? put_cell : '0;
            from_ram_reg <= !is_put && read_hit;
            written_reg  <= is_put && is_print;
            scrolled_reg <= is_put && scroll;
        end
    end

    tccw_ram #(
        .WIDTH (CLW),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign status.out_busy      = m_valid_reg && !m_ready;
    assign status.scroll        = is_put && scroll;
    assign status.cnt_last_cell = (cnt_reg == AW'(CELLS - 1));
    assign status.cnt_copy_last = (cnt_reg == AW'(CELLS - COLUMNS - 1));

    assign m_valid           = m_valid_reg;
    assign m_cursor_position = pos_reg;
    assign m_cell_address    = addr_reg;
    // read data stays in the ram output register until the next read
    assign m_cell_value      = from_ram_reg ? ram_rdata : value_reg;
    assign m_cell_written    = written_reg;
    assign m_scrolled        = scrolled_reg;

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_wr, put_wr, copy_pend_reg, cmd.blank_wr}))
        else $error("screen ram has more than one writer");

    a_scroll_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && status.scroll) |=> (m_valid && m_scrolled))
        else $error("scroll transaction not flagged in result");

    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(row_reg) < ROWS) && (int'(col_reg) < COLUMNS))
        else $error("cursor left the screen");

endmodule

`default_nettype wire

// File: design/text_console_char_writer_unit.sv
// top level of the text console character writer
// depends on tccw_pkg, tccw_ctrl and tccw_datapath
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------------
//  cfg      | cfg_wr_en         | cfg_wr_data (colour attribute)
//  s_ input | s_valid / s_ready | s_kind, s_char_code, s_read_address
//  m_ output| m_valid / m_ready | m_cursor_position, m_cell_address, m_cell_value,
//           |                   | m_cell_written, m_scrolled
//
// a put or read transaction is taken on the s_valid/s_ready handshake; the result register lets the next
// transaction in on the same edge the result is taken
// a put that scrolls keeps s_ready low while the screen moves up: one screen ram copy per cycle,
// a drain state that writes back the last copied cell, then one blank cell per cycle for the bottom row
// after reset a clearing pass fills the ram with blanks before s_ready rises; colour writes
// are taken at any time
`default_nettype none

module text_console_char_writer_unit #(
    parameter int COLUMNS  = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS     = tccw_pkg::ROWS_DEF,
    parameter int TAB_STOP = tccw_pkg::TAB_STOP_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tccw_pkg::ATTR_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [tccw_pkg::CHAR_W-1:0]   s_char_code,
    input  wire logic [tccw_pkg::ADDR_W-1:0]   s_read_address,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [tccw_pkg::ADDR_W-1:0]   m_cursor_position,
    output logic      [tccw_pkg::ADDR_W-1:0]   m_cell_address,
    output logic      [tccw_pkg::CELL_W-1:0]   m_cell_value,
    output logic                               m_cell_written,
    output logic                               m_scrolled
);

    tccw_pkg::ctrl_cmd_t  cmd;
    tccw_pkg::dp_status_t status;

    tccw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tccw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_kind            (s_kind),
        .s_char_code       (s_char_code),
        .s_read_address    (s_read_address),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_position (m_cursor_position),
        .m_cell_address    (m_cell_address),
        .m_cell_value      (m_cell_value),
        .m_cell_written    (m_cell_written),
        .m_scrolled        (m_scrolled)
    );

endmodule

`default_nettype wire
